FILE: design/scel_pkg.sv
package scel_pkg;

   localparam int SCEL_LOG_DEPTH = 64;
   localparam int STATE_BITS     = 4;
   localparam logic [3:0] STATE_MASK = 4'((1 << STATE_BITS) - 1);

   localparam logic [2:0] OP_SNAPSHOT = 3'd0;
   localparam logic [2:0] OP_BOOT     = 3'd1;
   localparam logic [2:0] OP_MANUAL   = 3'd2;
   localparam logic [2:0] OP_READ     = 3'd3;
   localparam logic [2:0] OP_CLEAR    = 3'd4;

   localparam logic [1:0] KIND_LOGGED = 2'd0;
   localparam logic [1:0] KIND_READ   = 2'd1;
   localparam logic [1:0] KIND_RANGE  = 2'd2;

   localparam int EV_BOOT          = 0;
   localparam int EV_STATE         = 1;
   localparam int EV_FAULT_RAISED  = 2;
   localparam int EV_FAULT_CHANGED = 3;
   localparam int EV_FAULT_CLEARED = 4;
   localparam int EV_PRE_START     = 5;
   localparam int EV_PRE_DONE      = 6;
   localparam int EV_PRE_TIMEOUT   = 7;
   localparam int EV_OCV           = 8;
   localparam int EV_MANUAL        = 9;
   localparam int EV_COUNT         = 10;

   typedef struct packed {
      logic [2:0]         opcode;
      logic [31:0]        stamp_ms;
      logic [3:0]         new_state;
      logic [9:0]         fault_bits;
      logic               pchg_active;
      logic               pchg_done;
      logic               pchg_needed;
      logic               pchg_expired;
      logic               ocv_applied;
      logic [15:0]        volt_mv;
      logic signed [31:0] curr_ma;
      logic [5:0]         read_index;
   } req_type;

   typedef struct packed {
      logic [1:0]         result_kind;
      logic [3:0]         event_code;
      logic [31:0]        event_time_ms;
      logic [3:0]         old_state;
      logic [3:0]         cur_state;
      logic [9:0]         event_faults;
      logic [15:0]        event_voltage_mv;
      logic signed [31:0] event_current_ma;
      logic [6:0]         stored_count;
      logic               last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  code;
      logic [31:0] time_ms;
      logic [3:0]  old_state;
      logic [3:0]  cur_state;
      logic [9:0]  faults;
   } head_type;

   typedef struct packed {
      logic [15:0]        voltage_mv;
      logic signed [31:0] current_ma;
   } measure_type;

   typedef struct packed {
      logic accept;
      logic emit_event;
      logic emit_read;
   } cmd_type;

   typedef struct packed {
      logic has_events;
      logic is_read;
      logic last_event;
      logic out_free;
   } status_type;

endpackage

FILE: design/status_change_event_logger_top.sv
// Status change event logger.
// Input channel (req_*): one request per opcode: snapshot, boot event, manual
// clear event, read entry, clear log. Result channel (rsp_*): logged events and
// read data, each with the entry count after it; last_of_run marks the final
// result of a request. Both channels use valid/stall handshakes.
// A snapshot is compared with the prior one and logs up to six events into a
// ring of LOG_DEPTH entries that overwrites the oldest; the first snapshot after
// reset or clear only primes the prior values.
// Flow: a request is taken while idle; each logged event then takes the ring
// write port in turn, and a snapshot holds the input until its last event is
// written. A read gives the ring its address when taken; the ring read port
// returns registered data in the cycle after the address. Clear, priming
// snapshots, snapshots with no change and unused opcodes give no result.
// Results pass through an output register; the next request is taken while the
// last result of the previous one still waits. A stalled result holds and the
// event sequence pauses until it is taken.
// Reset empties the log, unprimes, and drops any pending result.
module status_change_event_logger_top
   import scel_pkg::*;
#(
   parameter int LOG_DEPTH = SCEL_LOG_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   cmd_type    cmd;
   status_type status;

   scel_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   scel_datapath #(.LOG_DEPTH(LOG_DEPTH)) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

FILE: design/scel_ram.sv
module scel_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/scel_ctrl.sv
module scel_ctrl
   import scel_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_EVENTS = 2'd1;
   localparam logic [1:0] ST_READ   = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      cmd.accept     = (state_ff == ST_IDLE) && req_valid;
      cmd.emit_event = (state_ff == ST_EVENTS) && status.out_free;
      cmd.emit_read  = (state_ff == ST_READ) && status.out_free;
      req_stall      = (state_ff != ST_IDLE);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.accept) begin
               priority if (status.is_read) state_in = ST_READ;
               else if (status.has_events) state_in = ST_EVENTS;
               else state_in = ST_IDLE;
            end
         end
         ST_EVENTS: begin
            if (cmd.emit_event && status.last_event) state_in = ST_IDLE;
         end
         ST_READ: begin
            if (cmd.emit_read) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: design/scel_datapath.sv
module scel_datapath
   import scel_pkg::*;
#(
   parameter int LOG_DEPTH = SCEL_LOG_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_payload,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output rsp_type    rsp_payload,
   input  cmd_type    cmd,
   output status_type status
);

   localparam int AW = $clog2(LOG_DEPTH);
   localparam int CW = $clog2(LOG_DEPTH + 1);
   localparam int EW = CW + 7;
   localparam logic [CW-1:0] COUNT_FULL = CW'(LOG_DEPTH);
   localparam logic [AW-1:0] PTR_LAST   = AW'(LOG_DEPTH - 1);
   localparam logic [EW-1:0] DEPTH_EXT  = EW'(LOG_DEPTH);

   logic [AW-1:0]       wp_ff, wp_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                primed_ff, primed_in;
   logic [3:0]          prior_state_ff, prior_state_in;
   logic [9:0]          prior_faults_ff, prior_faults_in;
   logic [3:0]          prior_flags_ff, prior_flags_in;
   logic [EV_COUNT-1:0] pend_ff, pend_in;
   logic                in_range_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;
   head_type            hold_head_ff;
   measure_type         hold_meas_ff;

   logic [3:0]          st;
   logic [3:0]          flags;
   logic [3:0]          rise;
   logic [EV_COUNT-1:0] ev_mask;
   logic [EV_COUNT-1:0] pend_rest;
   logic [3:0]          code_sel;
   logic                is_snap;
   logic                is_event_op;
   logic                in_range;
   logic [AW-1:0]       oldest;
   logic [EW-1:0]       phys_sum;
   logic [EW-1:0]       phys_red;
   logic [AW-1:0]       phys;
   logic [CW-1:0]       count_inc;
   logic                out_free;
   head_type            head_wr, head_rd;
   measure_type         meas_rd;
   logic [EW-1:0]       count_ext;
   logic [EW-1:0]       count_inc_ext;

   assign st      = req_payload.new_state & STATE_MASK;
   assign flags   = {req_payload.ocv_applied, req_payload.pchg_expired,
                     req_payload.pchg_done, req_payload.pchg_active};
   assign rise    = flags & ~prior_flags_ff;
   assign is_snap = (req_payload.opcode == OP_SNAPSHOT);
   assign is_event_op = (req_payload.opcode == OP_BOOT) || (req_payload.opcode == OP_MANUAL);

   always_comb begin
      ev_mask = '0;
      unique case (req_payload.opcode)
         OP_SNAPSHOT: begin
            if (primed_ff) begin
               ev_mask[EV_STATE] = (st != prior_state_ff);
               if (req_payload.fault_bits != prior_faults_ff) begin
                  priority if (req_payload.fault_bits == '0) ev_mask[EV_FAULT_CLEARED] = 1'b1;
                  else if (prior_faults_ff != '0) ev_mask[EV_FAULT_CHANGED] = 1'b1;
                  else ev_mask[EV_FAULT_RAISED] = 1'b1;
               end
               ev_mask[EV_PRE_START]   = rise[0];
               ev_mask[EV_PRE_DONE]    = rise[1] && req_payload.pchg_needed;
               ev_mask[EV_PRE_TIMEOUT] = rise[2];
               ev_mask[EV_OCV]         = rise[3];
            end
         end
         OP_BOOT:   ev_mask[EV_BOOT] = 1'b1;
         OP_MANUAL: ev_mask[EV_MANUAL] = 1'b1;
         default:   ev_mask = '0;
      endcase
   end

   // chronological index to ring address
   assign count_ext = EW'(count_ff);
   assign in_range  = EW'(req_payload.read_index) < count_ext;
   assign oldest    = (count_ff == COUNT_FULL) ? wp_ff : '0;
   assign phys_sum  = EW'(oldest) + EW'(req_payload.read_index);
   assign phys_red  = (phys_sum >= DEPTH_EXT) ? (phys_sum - DEPTH_EXT) : phys_sum;
   assign phys      = phys_red[AW-1:0];

   // lowest pending event goes first
   always_comb begin
      code_sel = '0;
      for (int i = EV_COUNT - 1; i >= 0; i--) begin
         if (pend_ff[i]) code_sel = 4'(i);
      end
   end
   assign pend_rest = pend_ff & (pend_ff - EV_COUNT'(1));

   assign count_inc     = (count_ff == COUNT_FULL) ? count_ff : count_ff + CW'(1);
   assign count_inc_ext = EW'(count_inc);
   assign out_free      = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      head_wr      = hold_head_ff;
      head_wr.code = code_sel;
   end

   scel_ram #(.WIDTH($bits(head_type)), .DEPTH(LOG_DEPTH)) u_head_ram (
      .clock   (clock),
      .wr_en   (cmd.emit_event),
      .wr_addr (wp_ff),
      .wr_data (head_wr),
      .rd_en   (cmd.accept && is_event_op == 1'b0 && in_range),
      .rd_addr (phys),
      .rd_data (head_rd)
   );

   scel_ram #(.WIDTH($bits(measure_type)), .DEPTH(LOG_DEPTH)) u_meas_ram (
      .clock   (clock),
      .wr_en   (cmd.emit_event),
      .wr_addr (wp_ff),
      .wr_data (hold_meas_ff),
      .rd_en   (cmd.accept && is_event_op == 1'b0 && in_range),
      .rd_addr (phys),
      .rd_data (meas_rd)
   );

   always_comb begin
      wp_in           = wp_ff;
      count_in        = count_ff;
      primed_in       = primed_ff;
      prior_state_in  = prior_state_ff;
      prior_faults_in = prior_faults_ff;
      prior_flags_in  = prior_flags_ff;
      pend_in         = pend_ff;
      if (cmd.accept) begin
         pend_in = ev_mask;
         if (is_snap) begin
            primed_in       = 1'b1;
            prior_state_in  = st;
            prior_faults_in = req_payload.fault_bits;
            prior_flags_in  = flags;
         end
         if (req_payload.opcode == OP_CLEAR) begin
            wp_in           = '0;
            count_in        = '0;
            primed_in       = 1'b0;
            prior_state_in  = '0;
            prior_faults_in = '0;
            prior_flags_in  = '0;
         end
      end
      if (cmd.emit_event) begin
         pend_in  = pend_rest;
         wp_in    = (wp_ff == PTR_LAST) ? '0 : wp_ff + AW'(1);
         count_in = count_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff           <= '0;
         count_ff        <= '0;
         primed_ff       <= 1'b0;
         prior_state_ff  <= '0;
         prior_faults_ff <= '0;
         prior_flags_ff  <= '0;
         pend_ff         <= '0;
         in_range_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         wp_ff           <= wp_in;
         count_ff        <= count_in;
         primed_ff       <= primed_in;
         prior_state_ff  <= prior_state_in;
         prior_faults_ff <= prior_faults_in;
         prior_flags_ff  <= prior_flags_in;
         pend_ff         <= pend_in;
         if (cmd.accept) begin
            in_range_ff <= in_range;
         end
         if (cmd.emit_event || cmd.emit_read) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         hold_head_ff.code    <= '0;
         hold_head_ff.time_ms <= req_payload.stamp_ms;
         if (is_snap) begin
            hold_head_ff.old_state  <= prior_state_ff;
            hold_head_ff.cur_state  <= st;
            hold_head_ff.faults     <= req_payload.fault_bits;
            hold_meas_ff.voltage_mv <= req_payload.volt_mv;
            hold_meas_ff.current_ma <= req_payload.curr_ma;
         end else begin
            hold_head_ff.old_state  <= '0;
            hold_head_ff.cur_state  <= '0;
            hold_head_ff.faults     <= '0;
            hold_meas_ff.voltage_mv <= '0;
            hold_meas_ff.current_ma <= '0;
         end
      end
      if (cmd.emit_event) begin
         rsp_ff.result_kind      <= KIND_LOGGED;
         rsp_ff.event_code       <= code_sel;
         rsp_ff.event_time_ms    <= hold_head_ff.time_ms;
         rsp_ff.old_state        <= hold_head_ff.old_state;
         rsp_ff.cur_state        <= hold_head_ff.cur_state;
         rsp_ff.event_faults     <= hold_head_ff.faults;
         rsp_ff.event_voltage_mv <= hold_meas_ff.voltage_mv;
         rsp_ff.event_current_ma <= hold_meas_ff.current_ma;
         rsp_ff.stored_count     <= count_inc_ext[6:0];
         rsp_ff.last_of_run      <= (pend_rest == '0);
      end else if (cmd.emit_read) begin
         rsp_ff.stored_count <= count_ext[6:0];
         rsp_ff.last_of_run  <= 1'b1;
         if (in_range_ff) begin
            rsp_ff.result_kind      <= KIND_READ;
            rsp_ff.event_code       <= head_rd.code;
            rsp_ff.event_time_ms    <= head_rd.time_ms;
            rsp_ff.old_state        <= head_rd.old_state;
            rsp_ff.cur_state        <= head_rd.cur_state;
            rsp_ff.event_faults     <= head_rd.faults;
            rsp_ff.event_voltage_mv <= meas_rd.voltage_mv;
            rsp_ff.event_current_ma <= meas_rd.current_ma;
         end else begin
            rsp_ff.result_kind      <= KIND_RANGE;
            rsp_ff.event_code       <= '0;
            rsp_ff.event_time_ms    <= '0;
            rsp_ff.old_state        <= '0;
            rsp_ff.cur_state        <= '0;
            rsp_ff.event_faults     <= '0;
            rsp_ff.event_voltage_mv <= '0;
            rsp_ff.event_current_ma <= '0;
         end
      end
   end

   always_comb begin
      status.has_events = (ev_mask != '0);
      status.is_read    = (req_payload.opcode == OP_READ);
      status.last_event = (pend_rest == '0);
      status.out_free   = out_free;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: design/scel_checker.sv
module scel_checker
   import scel_pkg::*;
#(
   parameter int LOG_DEPTH = SCEL_LOG_DEPTH
) (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_payload.opcode == OP_READ |=> req_stall)
      else $error("read request not held busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.result_kind == KIND_RANGE |->
         rsp_payload.event_code == '0 && rsp_payload.event_time_ms == '0 &&
         rsp_payload.last_of_run)
      else $error("out of range read carries data");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (LOG_DEPTH > 127) || (int'(rsp_payload.stored_count) <= LOG_DEPTH))
      else $error("entry count beyond depth");

endmodule

bind status_change_event_logger_top scel_checker #(.LOG_DEPTH(LOG_DEPTH)) u_scel_checker (.*);
